FILE: rtl/core/lsnw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LCD signed number writer package
// Constants and the stage type shared by the number formatter and emitter.
// ----------------------------------------------------------------------------
package lsnw_pkg;

    localparam int ADDR_W  = 8;
    localparam int MAG_W   = 10;
    localparam int DIGIT_W = 4;
    localparam int REM_W   = 7;
    localparam int POS_W   = 2;
    localparam int FIELD_LEN = 4;

    localparam logic [ADDR_W-1:0] ROW1_BASE   = 8'h80;
    localparam logic [ADDR_W-1:0] ROW2_BASE   = 8'hC0;
    localparam logic [7:0]        ASCII_ZERO  = 8'd48;
    localparam logic [7:0]        ASCII_MINUS = 8'h2D;
    localparam logic [MAG_W-1:0]  MAX_MAG     = 10'd999;

    localparam logic REG_SEL_CMD  = 1'b0;
    localparam logic REG_SEL_DATA = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr0;
        logic               neg;
        logic [DIGIT_W-1:0] hund;
        logic [REM_W-1:0]   rem;
    } fmt_t;

endpackage
`default_nettype wire

FILE: rtl/core/lsnw_magnitude.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LCD signed number writer magnitude stage
// Registers the input word, forms the saturated magnitude, the hundreds
// digit, the remainder below one hundred and the field start address.
// ----------------------------------------------------------------------------
module lsnw_magnitude (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_row_sel,
    input  wire logic [4:0]          s_column,
    input  wire logic signed [10:0]  s_value,
    output logic                     fmt_valid,
    input  wire logic                fmt_take,
    output lsnw_pkg::fmt_t           fmt
);
    import lsnw_pkg::*;

    logic              a_valid_reg;
    logic              a_row_reg;
    logic [4:0]        a_col_reg;
    logic [10:0]       a_value_reg;
    logic              b_valid_reg;
    fmt_t              b_fmt_reg;
    fmt_t              b_fmt_next;
    logic              a_adv;
    logic              neg;
    logic [10:0]       mag_raw;
    logic [MAG_W-1:0]  mag;
    logic [DIGIT_W-1:0] hund;
    logic [MAG_W-1:0]  rem_w;

    assign a_adv   = a_valid_reg && (!b_valid_reg || fmt_take);
    assign s_ready = !a_valid_reg || a_adv;

    always_comb begin
        neg     = a_value_reg[10];
        mag_raw = neg ? 11'(~a_value_reg + 11'd1) : a_value_reg;
        mag     = (mag_raw > {1'b0, MAX_MAG}) ? MAX_MAG : mag_raw[MAG_W-1:0];
        hund    = '0;
        for (int i = 1; i < 10; i++) begin
            if (mag >= MAG_W'(i * 100)) begin
                hund = DIGIT_W'(i);
            end
        end
        rem_w = mag - MAG_W'({6'd0, hund} * 10'd100);
        b_fmt_next.addr0 = (a_row_reg ? ROW2_BASE : ROW1_BASE)
                           + {3'd0, a_col_reg} - 8'd1;
        b_fmt_next.neg   = neg;
        b_fmt_next.hund  = hund;
        b_fmt_next.rem   = rem_w[REM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                a_valid_reg <= s_valid;
            end
            if (!b_valid_reg || fmt_take) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            a_row_reg   <= s_row_sel;
            a_col_reg   <= s_column;
            a_value_reg <= s_value;
        end
        if (a_adv) begin
            b_fmt_reg <= b_fmt_next;
        end
    end

    assign fmt_valid = b_valid_reg;
    assign fmt       = b_fmt_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        fmt_take |-> fmt_valid)
        else $error("Formatter word taken while empty.");
    assert property (@(posedge aclk) disable iff (!aresetn)
        fmt_valid && !fmt_take |=> fmt_valid && $stable(b_fmt_reg))
        else $error("Formatter word changed while held.");
    assert property (@(posedge aclk) disable iff (!aresetn)
        fmt_valid |-> (b_fmt_reg.hund <= 4'd9) && (b_fmt_reg.rem <= 7'd99))
        else $error("Digit split out of range.");

endmodule
`default_nettype wire

FILE: rtl/core/lsnw_emitter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LCD signed number writer emitter
// Splits the remainder into tens and ones, lays out the field characters
// and sends one set-address and one character write per drawn position.
// ----------------------------------------------------------------------------
module lsnw_emitter (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            fmt_valid,
    output logic                 fmt_take,
    input  wire lsnw_pkg::fmt_t  fmt,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic                 m_reg_select,
    output logic [7:0]           m_bus_byte,
    output logic                 m_last
);
    import lsnw_pkg::*;

    logic                em_valid_reg;
    logic [POS_W-1:0]    pos_reg;
    logic                phase_reg;
    logic [ADDR_W-1:0]   addr0_reg;
    logic [7:0]          ch_reg [FIELD_LEN];
    logic [DIGIT_W-1:0]  tens;
    logic [DIGIT_W-1:0]  ones;
    logic [REM_W-1:0]    ones_w;
    logic                has_hund;
    logic                has_tens;
    logic [POS_W-1:0]    start_pos;
    logic [7:0]          ch_next [FIELD_LEN];
    logic                out_take;
    logic                end_beat;

    assign out_take = em_valid_reg && m_ready;
    assign end_beat = phase_reg && (pos_reg == POS_W'(FIELD_LEN - 1));
    assign fmt_take = fmt_valid && (!em_valid_reg || (m_ready && end_beat));

    always_comb begin
        tens = '0;
        for (int i = 1; i < 10; i++) begin
            if (fmt.rem >= REM_W'(i * 10)) begin
                tens = DIGIT_W'(i);
            end
        end
        ones_w   = fmt.rem - REM_W'({3'd0, tens} * 7'd10);
        ones     = ones_w[DIGIT_W-1:0];
        has_hund = (fmt.hund != '0);
        has_tens = has_hund || (tens != '0);
        if (has_hund) begin
            start_pos = fmt.neg ? 2'd0 : 2'd1;
        end else if (has_tens) begin
            start_pos = fmt.neg ? 2'd1 : 2'd2;
        end else begin
            start_pos = fmt.neg ? 2'd2 : 2'd3;
        end
        ch_next[0] = ASCII_MINUS;
        ch_next[1] = has_hund ? (ASCII_ZERO + {4'd0, fmt.hund}) : ASCII_MINUS;
        ch_next[2] = has_tens ? (ASCII_ZERO + {4'd0, tens}) : ASCII_MINUS;
        ch_next[3] = ASCII_ZERO + {4'd0, ones};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            em_valid_reg <= 1'b0;
            pos_reg      <= '0;
            phase_reg    <= REG_SEL_CMD;
        end else if (fmt_take) begin
            em_valid_reg <= 1'b1;
            pos_reg      <= start_pos;
            phase_reg    <= REG_SEL_CMD;
        end else if (out_take) begin
            if (phase_reg == REG_SEL_CMD) begin
                phase_reg <= REG_SEL_DATA;
            end else if (end_beat) begin
                em_valid_reg <= 1'b0;
            end else begin
                phase_reg <= REG_SEL_CMD;
                pos_reg   <= pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fmt_take) begin
            addr0_reg <= fmt.addr0;
            for (int i = 0; i < FIELD_LEN; i++) begin
                ch_reg[i] <= ch_next[i];
            end
        end
    end

    assign m_valid      = em_valid_reg;
    assign m_reg_select = phase_reg;
    assign m_bus_byte   = phase_reg ? ch_reg[pos_reg] : addr0_reg + {6'd0, pos_reg};
    assign m_last       = end_beat;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_reg_select)
        else $error("Last word is not a character write.");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_reg_select |=> m_valid && m_reg_select
                                                && $stable(pos_reg))
        else $error("Address write not followed by its character.");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_reg_select && !m_last
            |=> m_valid && !m_reg_select && (pos_reg == $past(pos_reg) + 2'd1))
        else $error("Field position did not step.");
    assert property (@(posedge aclk) disable iff (!aresetn)
        fmt_take |-> !em_valid_reg || (m_ready && m_last))
        else $error("New number loaded over an unfinished one.");

endmodule
`default_nettype wire

FILE: rtl/core/lcd_signed_number_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LCD signed number writer
// Formats a signed number into a right-aligned four-character field on a
// two-line character LCD as a series of bus writes.
//
// The s_ channel takes one word per number: row, starting column and an
// 11-bit signed value, saturated to plus or minus 999. The m_ channel gives
// the LCD bus writes: a set-address command (reg_select low) and then the
// character (reg_select high) for each drawn position, m_last on the final
// character. A number yields 2 to 8 words, twice its drawn character
// count, one per cycle while m_ready is high. The first word of a number
// reaches the output through the input register, the digit register and
// the output register. Up to two further numbers are taken while one is
// being sent, so back-to-back numbers leave no gap on the output. When
// m_ready is low the current word holds and the input side fills, then
// drops s_ready. Reset clears all valid flags; the block takes input the
// cycle after it.
// ----------------------------------------------------------------------------
module lcd_signed_number_writer (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_row_sel,
    input  wire logic [4:0]         s_column,
    input  wire logic signed [10:0] s_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_reg_select,
    output logic [7:0]              m_bus_byte,
    output logic                    m_last
);
    import lsnw_pkg::*;

    logic fmt_valid;
    logic fmt_take;
    fmt_t fmt;

    lsnw_magnitude u_magnitude (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_row_sel (s_row_sel),
        .s_column  (s_column),
        .s_value   (s_value),
        .fmt_valid (fmt_valid),
        .fmt_take  (fmt_take),
        .fmt       (fmt)
    );

    lsnw_emitter u_emitter (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fmt_valid    (fmt_valid),
        .fmt_take     (fmt_take),
        .fmt          (fmt),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_reg_select (m_reg_select),
        .m_bus_byte   (m_bus_byte),
        .m_last       (m_last)
    );

endmodule
`default_nettype wire
